@@ hw/rtl/min_heap_timer_queue_assert.svh @@
// Assertion macros for the timer queue RTL.
// Depends on signals named clk and rst_n in the including module.
`ifndef MIN_HEAP_TIMER_QUEUE_ASSERT_SVH
`define MIN_HEAP_TIMER_QUEUE_ASSERT_SVH

// Checked only out of reset.
`define MHTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define MHTQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/mhtq_pkg.sv @@
// Shared constants for the min-heap timer queue.
// No dependencies.
`default_nettype none
package mhtq_pkg;
  localparam int CAPACITY = 64;
  localparam int ADDR_W   = 6;
  localparam int CNT_W    = 7;
  localparam int ID_W     = 8;
  localparam int TIME_W   = 32;
  localparam int ID_COUNT = 256;
  localparam int HEAP_W   = ID_W + TIME_W;
  localparam int RES_W    = 1 + ID_W + TIME_W;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_CANCEL = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;
  localparam logic [1:0] ACT_DEL    = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
endpackage
`default_nettype wire

@@ hw/rtl/mhtq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mhtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hw/rtl/min_heap_timer_queue.sv @@
// Timer queue: binary min-heap of (id, expiry) pairs held in RAM, with a
// cancel-mark RAM and a result buffer. Depends on mhtq_pkg, mhtq_ram and
// min_heap_timer_queue_assert.svh.
//
// One transfer is taken at a time. Add sifts up by reading each parent in
// turn, and a pop sifts down with up to two child reads per level through the
// single heap RAM read port. Results of a step are buffered and sent after
// the step ends. After reset the block clears all 256 cancel marks with
// in_tready low.
`default_nettype none
module min_heap_timer_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // timer_id[7:0], expire_time[39:8], current_time[71:40]
  input  wire logic [71:0] in_tdata,
  // action[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // popped_id[7:0], popped_expire[39:8], top_valid[40], top_id[48:41],
  // top_expire[80:49], entry_count[87:81], status[89:88], zero[95:90]
  output logic [95:0]      out_tdata,
  // popped_valid[0], fired[1]
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);
  import mhtq_pkg::*;
  `include "min_heap_timer_queue_assert.svh"

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_UP_RD = 4'd2, S_UP_CMP = 4'd3,
    S_TK_CHK = 4'd4, S_TK_TEST = 4'd5, S_POP = 4'd6, S_DN_LD = 4'd7, S_DN_RL = 4'd8,
    S_DN_RR = 4'd9, S_DN_RC = 4'd10, S_TOP = 4'd11, S_TOPW = 4'd12, S_ERD = 4'd13,
    S_ELD = 4'd14, S_EWT = 4'd15;

  logic [3:0]        st_r, st_nxt;
  logic [CNT_W-1:0]  size_r, size_nxt, rcnt_r, rcnt_nxt, ecnt_r, ecnt_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [TIME_W-1:0] te_r, te_nxt, now_r, now_nxt, pexp_r, pexp_nxt, lexp_r, lexp_nxt;
  logic [ID_W-1:0]   ti_r, ti_nxt, pid_r, pid_nxt, lid_r, lid_nxt;
  logic [1:0]        act_r, act_nxt, status_r, status_nxt;
  logic [7:0]        clr_r, clr_nxt;
  logic              topv_r, topv_nxt;
  logic [ID_W-1:0]   topid_r, topid_nxt;
  logic [TIME_W-1:0] topexp_r, topexp_nxt;
  logic              ov_r, ov_nxt, opv_r, opv_nxt, ofired_r, ofired_nxt, olast_r, olast_nxt;
  logic [ID_W-1:0]   oid_r, oid_nxt;
  logic [TIME_W-1:0] oexp_r, oexp_nxt;

  logic              h_we;
  logic [ADDR_W-1:0] h_waddr, h_raddr;
  logic [HEAP_W-1:0] h_wdata, h_rdata;
  logic              m_we, m_wdata, m_rdata;
  logic [ID_W-1:0]   m_waddr, m_raddr;
  logic              b_we;
  logic [ADDR_W-1:0] b_waddr, b_raddr;
  logic [RES_W-1:0]  b_wdata, b_rdata;

  logic [ID_W-1:0]   r_id, cand_id;
  logic [TIME_W-1:0] r_exp, cand_exp;
  logic [ADDR_W-1:0] parent, cand_addr;
  logic [CNT_W-1:0]  child, size_m1;
  logic              in_xfer;

  mhtq_ram #(.WIDTH(HEAP_W), .DEPTH(CAPACITY)) u_heap (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata));
  mhtq_ram #(.WIDTH(1), .DEPTH(ID_COUNT)) u_marks (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata));
  mhtq_ram #(.WIDTH(RES_W), .DEPTH(CAPACITY)) u_res (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(b_raddr), .rdata(b_rdata));

  assign r_id    = h_rdata[HEAP_W-1:TIME_W];
  assign r_exp   = h_rdata[TIME_W-1:0];
  assign parent  = ADDR_W'((pos_r - ADDR_W'(1)) >> 1);
  assign child   = {pos_r, 1'b1};
  assign size_m1 = size_r - CNT_W'(1);
  assign in_tready = (st_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    st_nxt = st_r; size_nxt = size_r; rcnt_nxt = rcnt_r; ecnt_nxt = ecnt_r;
    pos_nxt = pos_r; te_nxt = te_r; ti_nxt = ti_r; now_nxt = now_r;
    pexp_nxt = pexp_r; pid_nxt = pid_r; lexp_nxt = lexp_r; lid_nxt = lid_r;
    act_nxt = act_r; status_nxt = status_r; clr_nxt = clr_r;
    topv_nxt = topv_r; topid_nxt = topid_r; topexp_nxt = topexp_r;
    ov_nxt = ov_r; opv_nxt = opv_r; ofired_nxt = ofired_r; olast_nxt = olast_r;
    oid_nxt = oid_r; oexp_nxt = oexp_r;
    h_we = 1'b0; h_waddr = pos_r; h_wdata = {ti_r, te_r}; h_raddr = '0;
    m_we = 1'b0; m_waddr = in_tdata[7:0]; m_wdata = 1'b0; m_raddr = r_id;
    b_we = 1'b0; b_waddr = rcnt_r[ADDR_W-1:0];
    b_wdata = {(act_r == ACT_TICK) && !m_rdata, pid_r, pexp_r};
    b_raddr = ecnt_r[ADDR_W-1:0];
    cand_id = lid_r; cand_exp = lexp_r; cand_addr = child[ADDR_W-1:0];

    unique case (st_r)
      S_CLR: begin
        m_we = 1'b1; m_waddr = clr_r; m_wdata = 1'b0;
        clr_nxt = clr_r + 8'd1;
        if (clr_r == 8'hFF) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          act_nxt = in_tuser; status_nxt = ST_OK; rcnt_nxt = '0; ecnt_nxt = '0;
          now_nxt = in_tdata[71:40];
          unique case (in_tuser)
            ACT_ADD: begin
              if (size_r >= CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL; st_nxt = S_TOP;
              end else begin
                te_nxt = in_tdata[39:8]; ti_nxt = in_tdata[7:0];
                pos_nxt = size_r[ADDR_W-1:0]; size_nxt = size_r + CNT_W'(1);
                m_we = 1'b1; m_wdata = 1'b0; st_nxt = S_UP_RD;
              end
            end
            ACT_CANCEL: begin
              m_we = 1'b1; m_wdata = 1'b1; st_nxt = S_TOP;
            end
            ACT_TICK: st_nxt = S_TK_CHK;
            ACT_DEL: begin
              if (size_r == '0) begin
                status_nxt = ST_EMPTY; st_nxt = S_TOP;
              end else begin
                h_raddr = '0; st_nxt = S_TK_TEST;
              end
            end
            default: st_nxt = S_TOP;
          endcase
        end
      end
      S_UP_RD: begin
        if (pos_r == '0) begin
          h_we = 1'b1; st_nxt = S_TOP;
        end else begin
          h_raddr = parent; st_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        h_we = 1'b1;
        if (r_exp <= te_r) begin
          st_nxt = S_TOP;
        end else begin
          h_wdata = h_rdata; pos_nxt = parent; st_nxt = S_UP_RD;
        end
      end
      S_TK_CHK: begin
        if (size_r == '0) begin
          st_nxt = S_TOP;
        end else begin
          h_raddr = '0; st_nxt = S_TK_TEST;
        end
      end
      S_TK_TEST: begin
        if (act_r == ACT_DEL || r_exp <= now_r) begin
          pid_nxt = r_id; pexp_nxt = r_exp; m_raddr = r_id; st_nxt = S_POP;
        end else begin
          st_nxt = S_TOP;
        end
      end
      S_POP: begin
        b_we = 1'b1; rcnt_nxt = rcnt_r + CNT_W'(1); size_nxt = size_m1;
        if (size_m1 == '0) begin
          st_nxt = (act_r == ACT_TICK) ? S_TK_CHK : S_TOP;
        end else begin
          h_raddr = size_m1[ADDR_W-1:0]; st_nxt = S_DN_LD;
        end
      end
      S_DN_LD: begin
        te_nxt = r_exp; ti_nxt = r_id; pos_nxt = '0; st_nxt = S_DN_RL;
      end
      S_DN_RL: begin
        if (child >= size_r) begin
          h_we = 1'b1; st_nxt = (act_r == ACT_TICK) ? S_TK_CHK : S_TOP;
        end else begin
          h_raddr = child[ADDR_W-1:0]; st_nxt = S_DN_RR;
        end
      end
      S_DN_RR, S_DN_RC: begin
        if (st_r == S_DN_RR) begin
          lexp_nxt = r_exp; lid_nxt = r_id;
          cand_id = r_id; cand_exp = r_exp;
        end else if (lexp_r > r_exp) begin
          cand_id = r_id; cand_exp = r_exp; cand_addr = child[ADDR_W-1:0] + ADDR_W'(1);
        end
        if (st_r == S_DN_RR && ({1'b0, child} + 8'd1) < {1'b0, size_r}) begin
          h_raddr = child[ADDR_W-1:0] + ADDR_W'(1); st_nxt = S_DN_RC;
        end else if (te_r <= cand_exp) begin
          h_we = 1'b1; st_nxt = (act_r == ACT_TICK) ? S_TK_CHK : S_TOP;
        end else begin
          h_we = 1'b1; h_wdata = {cand_id, cand_exp}; pos_nxt = cand_addr;
          st_nxt = S_DN_RL;
        end
      end
      S_TOP: begin
        if (size_r != '0) begin
          h_raddr = '0; st_nxt = S_TOPW;
        end else begin
          topv_nxt = 1'b0; topid_nxt = '0; topexp_nxt = '0; st_nxt = S_ERD;
        end
      end
      S_TOPW: begin
        topv_nxt = 1'b1; topid_nxt = r_id; topexp_nxt = r_exp; st_nxt = S_ERD;
      end
      S_ERD: begin
        if (rcnt_r == '0) begin
          ov_nxt = 1'b1; opv_nxt = 1'b0; ofired_nxt = 1'b0; oid_nxt = '0; oexp_nxt = '0;
          olast_nxt = 1'b1; st_nxt = S_EWT;
        end else begin
          st_nxt = S_ELD;
        end
      end
      S_ELD: begin
        ov_nxt = 1'b1; opv_nxt = 1'b1; ofired_nxt = b_rdata[RES_W-1];
        oid_nxt = b_rdata[RES_W-2:TIME_W]; oexp_nxt = b_rdata[TIME_W-1:0];
        olast_nxt = (ecnt_r + CNT_W'(1)) == rcnt_r; st_nxt = S_EWT;
      end
      S_EWT: begin
        if (out_tready) begin
          ov_nxt = 1'b0; ecnt_nxt = ecnt_r + CNT_W'(1);
          st_nxt = olast_r ? S_IDLE : S_ERD;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; size_r <= '0; clr_r <= '0; ov_r <= 1'b0;
      rcnt_r <= '0; ecnt_r <= '0; act_r <= ACT_ADD; status_r <= ST_OK;
    end else begin
      st_r <= st_nxt; size_r <= size_nxt; clr_r <= clr_nxt; ov_r <= ov_nxt;
      rcnt_r <= rcnt_nxt; ecnt_r <= ecnt_nxt; act_r <= act_nxt; status_r <= status_nxt;
    end
    pos_r <= pos_nxt; te_r <= te_nxt; ti_r <= ti_nxt; now_r <= now_nxt;
    pexp_r <= pexp_nxt; pid_r <= pid_nxt; lexp_r <= lexp_nxt; lid_r <= lid_nxt;
    topv_r <= topv_nxt; topid_r <= topid_nxt; topexp_r <= topexp_nxt;
    opv_r <= opv_nxt; ofired_r <= ofired_nxt; olast_r <= olast_nxt;
    oid_r <= oid_nxt; oexp_r <= oexp_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = {ofired_r, opv_r};
  assign out_tdata  = {6'd0, status_r, size_r, topexp_r, topid_r, topv_r, oexp_r, oid_r};

  `MHTQ_ASSERT(a_size_bound, size_r <= CNT_W'(CAPACITY), "heap size beyond capacity")
  `MHTQ_ASSERT(a_res_bound, rcnt_r <= size_r + rcnt_r && rcnt_r <= CNT_W'(CAPACITY), "result count overflow")
  `MHTQ_ASSERT(a_valid_state, out_tvalid |-> st_r == S_EWT, "result shown outside emit wait")
  `MHTQ_ASSERT(a_take_leaves_idle, in_tvalid && in_tready |=> st_r != S_IDLE, "transfer not started")
  `MHTQ_ASSERT_ALWAYS(a_no_take_in_clear, st_r == S_CLR |-> !in_tready, "input taken while clearing")
endmodule
`default_nettype wire
